// ----- rtl/core/ghm_pkg.sv -----
// Package for the grayscale horizontal mirror block.
// Holds command codes, register map constants and the gray weighting function.
// No dependencies.
`timescale 1ns / 1ps

package ghm_pkg;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH = 1'b0;

  localparam int unsigned IMG_WIDTH_W = 12;
  localparam logic [IMG_WIDTH_W-1:0] IMG_WIDTH_RESET = 12'd2048;

  // 0.21, 0.72, 0.07 in unsigned Q0.8, rounded
  localparam logic [7:0] WEIGHT_RED   = 8'd54;
  localparam logic [7:0] WEIGHT_GREEN = 8'd184;
  localparam logic [7:0] WEIGHT_BLUE  = 8'd18;

  function automatic logic [7:0] to_gray(input logic [7:0] red, input logic [7:0] green,
                                         input logic [7:0] blue);
    logic [15:0] sum;
    sum = 16'(red) * 16'(WEIGHT_RED) + 16'(green) * 16'(WEIGHT_GREEN)
        + 16'(blue) * 16'(WEIGHT_BLUE);
    return sum[15:8];
  endfunction

endpackage

// ----- rtl/core/ghm_stream_if.sv -----
// Valid/ready stream interfaces for the grayscale horizontal mirror block.
// Pixel input channel and mirrored gray result channel. No dependencies.
`timescale 1ns / 1ps

interface ghm_pixel_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, command, blue, green, red, input ready);
  modport sink (input valid, command, blue, green, red, output ready);
endinterface

interface ghm_gray_if;
  logic       valid;
  logic       ready;
  logic [7:0] gray;
  logic       row_last;

  modport source (output valid, gray, row_last, input ready);
  modport sink (input valid, gray, row_last, output ready);
endinterface

// ----- rtl/core/grayscale_horizontal_mirror_top.sv -----
// Grayscale conversion with horizontal mirror through a ping-pong line memory.
// Each result passes the line memory read register and then the output register.
// Throughput: one beat per cycle; the line memory read register and the output
// register form a two-entry queue, so input stalls only when both are held.
// Reset (rst, synchronous): columns, bank and pending row cleared, image_width = 2048.
// Line memory contents are not cleared. Depends on ghm_pkg and ghm_stream_if.
`timescale 1ns / 1ps

module grayscale_horizontal_mirror_top #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ghm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [ghm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [ghm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  ghm_pixel_if.sink                         pixel,
  ghm_gray_if.source                        result
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW    = (COL_W + 1 > ghm_pkg::IMG_WIDTH_W) ? COL_W + 1
                                                                      : ghm_pkg::IMG_WIDTH_W;
  localparam int unsigned DEPTH = 2 * MAX_WIDTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [ghm_pkg::IMG_WIDTH_W-1:0] image_width;
  logic [COL_W-1:0]                write_column;
  logic [COL_W-1:0]                read_column;
  logic                            write_bank;
  logic                            row_pending;

  logic [7:0] line_store [DEPTH];

  logic       s1_valid;
  logic [7:0] s1_gray;
  logic       s1_last;
  logic       out_valid;
  logic [7:0] out_gray;
  logic       out_last;

  logic          s1_move;
  logic          accept;
  logic          is_pixel;
  logic [CW-1:0] width_ext;
  logic [CW-1:0] eff_width;
  logic [CW-1:0] width_m1;
  logic [CW-1:0] rc_ext;
  logic [COL_W-1:0] rd_col;
  logic          rd_last;
  logic          wr_last;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [7:0]    pixel_gray;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= ghm_pkg::IMG_WIDTH_RESET;
    end else if (psel && penable && pwrite && paddr == ghm_pkg::REG_IMAGE_WIDTH) begin
      image_width <= pwdata[ghm_pkg::IMG_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ghm_pkg::REG_IMAGE_WIDTH) begin
      prdata = ghm_pkg::CFG_DATA_W'(image_width);
    end
  end

  // effective width and addressing
  always_comb begin
    width_ext = CW'(image_width);
    if (width_ext == '0) begin
      eff_width = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      eff_width = CW'(MAX_WIDTH);
    end else begin
      eff_width = width_ext;
    end
    width_m1 = eff_width - CW'(1);
    rc_ext   = CW'(read_column);
    rd_col   = (rc_ext < eff_width) ? COL_W'(width_m1 - rc_ext) : '0;
    rd_last  = rc_ext >= width_m1;
    wr_last  = CW'(write_column) >= width_m1;
    rd_addr  = AW'(rd_col) + (write_bank ? '0 : AW'(MAX_WIDTH));
    wr_addr  = AW'(write_column) + (write_bank ? AW'(MAX_WIDTH) : '0);
  end

  assign pixel_gray = ghm_pkg::to_gray(pixel.red, pixel.green, pixel.blue);

  // handshake
  assign s1_move     = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_move;
  assign accept      = pixel.valid && pixel.ready;
  assign is_pixel    = pixel.command == ghm_pkg::CMD_PIXEL;

  // line memory
  always_ff @(posedge clk) begin
    if (accept && is_pixel) begin
      line_store[wr_addr] <= pixel_gray;
    end
    if (accept && row_pending) begin
      s1_gray <= line_store[rd_addr];
      s1_last <= rd_last;
    end
  end

  // column and bank control; a completed row takes over the pending one
  always_ff @(posedge clk) begin
    if (rst) begin
      write_column <= '0;
      read_column  <= '0;
      write_bank   <= 1'b0;
      row_pending  <= 1'b0;
    end else if (accept) begin
      if (is_pixel && wr_last) begin
        write_column <= '0;
        write_bank   <= ~write_bank;
        read_column  <= '0;
        row_pending  <= 1'b1;
      end else begin
        if (is_pixel) begin
          write_column <= write_column + COL_W'(1);
        end
        if (row_pending) begin
          if (rd_last) begin
            read_column <= '0;
            row_pending <= 1'b0;
          end else begin
            read_column <= read_column + COL_W'(1);
          end
        end
      end
    end
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept && row_pending) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_gray <= s1_gray;
      out_last <= s1_last;
    end
  end

  assign result.valid    = out_valid;
  assign result.gray     = out_gray;
  assign result.row_last = out_last;

endmodule

// ----- dv/tb_grayscale_horizontal_mirror_top.sv -----
// Self-checking testbench for grayscale_horizontal_mirror_top: pixel beats go in, and a
// built-in line-store predictor checks every mirrored gray beat against its queue.
// Depends on ghm_pkg, ghm_stream_if and the top level; needs nothing else.
`timescale 1ns / 1ps

module tb_grayscale_horizontal_mirror_top;

  localparam int unsigned MAX_W = 2048;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [7:0] gray;
    logic       row_last;
  } mirror_beat_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ghm_pkg::CFG_ADDR_W-1:0] paddr;
  logic [ghm_pkg::CFG_DATA_W-1:0] pwdata;
  logic [ghm_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  ghm_pixel_if pixel_bus ();
  ghm_gray_if gray_bus ();

  grayscale_horizontal_mirror_top dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .pixel(pixel_bus),
    .result(gray_bus)
  );

  // mirror predictor state
  logic [7:0] line_mem [2][MAX_W];
  int unsigned bank_fill [2];
  int unsigned wr_col;
  int unsigned rd_col;
  logic wr_bank;
  logic row_pend;
  logic [ghm_pkg::IMG_WIDTH_W-1:0] img_width;

  mirror_beat_t mirror_q [$];
  int unsigned errors;
  int unsigned stall_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (errors < 100) $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned eff_width(input logic [ghm_pkg::IMG_WIDTH_W-1:0] w);
    if (w == 0) return 1;
    if (int'(w) > MAX_W) return MAX_W;
    return int'(w);
  endfunction

  function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    int unsigned acc;
    acc = 54 * int'(r) + 184 * int'(g) + 18 * int'(b);
    return 8'(acc >> 8);
  endfunction

  task automatic predict_beat(input logic cmd, input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r);
    int unsigned w;
    int unsigned col;
    mirror_beat_t nxt;
    w = eff_width(img_width);
    if (row_pend) begin
      col = (rd_col < w) ? w - 1 - rd_col : 0;
      nxt.gray = line_mem[~wr_bank][col];
      nxt.row_last = (rd_col >= w - 1);
      mirror_q.push_back(nxt);
      if (nxt.row_last) begin
        rd_col = 0;
        row_pend = 1'b0;
      end else begin
        rd_col++;
      end
    end
    if (cmd == ghm_pkg::CMD_PIXEL) begin
      line_mem[wr_bank][wr_col] = gray_of(r, g, b);
      if (wr_col + 1 > bank_fill[wr_bank]) bank_fill[wr_bank] = wr_col + 1;
      if (wr_col >= w - 1) begin
        wr_col = 0;
        wr_bank = ~wr_bank;
        rd_col = 0;
        row_pend = 1'b1;
      end else begin
        wr_col++;
      end
    end
  endtask

  // returns at the edge where the beat is taken
  task automatic send_item(input logic cmd, input logic [7:0] b, input logic [7:0] g,
                           input logic [7:0] r);
    while ($urandom_range(99) < stall_pct) begin
      pixel_bus.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.command <= cmd;
    pixel_bus.blue <= b;
    pixel_bus.green <= g;
    pixel_bus.red <= r;
    do @(posedge clk); while (!pixel_bus.ready);
    predict_beat(cmd, b, g, r);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel();
    send_item(ghm_pkg::CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic send_drain();
    send_item(ghm_pkg::CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
  endtask

  task automatic settle_block();
    pixel_bus.valid <= 1'b0;
    while (mirror_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [ghm_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [ghm_pkg::CFG_DATA_W-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ghm_pkg::REG_IMAGE_WIDTH;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_width_reg();
    logic [ghm_pkg::CFG_DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd !== ghm_pkg::CFG_DATA_W'(img_width))
      report_mismatch($sformatf("image_width read %0d, want %0d", rd, img_width));
  endtask

  // growing the width while a row is pending must not reach unwritten line entries
  task automatic set_image_width(input logic [ghm_pkg::IMG_WIDTH_W-1:0] value);
    logic [ghm_pkg::CFG_DATA_W-1:0] rd;
    int unsigned new_w;
    new_w = eff_width(value);
    settle_block();
    if (row_pend && new_w > eff_width(img_width) && new_w > bank_fill[~wr_bank]) begin
      while (row_pend) send_drain();
      settle_block();
    end
    apb_access(1'b1, ghm_pkg::CFG_DATA_W'(value), rd);
    img_width = value;
    check_width_reg();
  endtask

  task automatic test_register_reset();
    check_width_reg();
  endtask

  task automatic test_directed_corners();
    set_image_width(12'd4);
    send_drain();
    send_item(ghm_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'h00);
    send_item(ghm_pkg::CMD_PIXEL, 8'hff, 8'hff, 8'hff);
    send_item(ghm_pkg::CMD_PIXEL, 8'hff, 8'h00, 8'h00);
    send_item(ghm_pkg::CMD_PIXEL, 8'h00, 8'hff, 8'h00);
    send_item(ghm_pkg::CMD_PIXEL, 8'h00, 8'h00, 8'hff);
    send_item(ghm_pkg::CMD_PIXEL, 8'h55, 8'haa, 8'h55);
    send_drain();
    send_drain();
    send_drain();
    // partial row of two kept; width 0 acts as 1
    set_image_width(12'd0);
    send_item(ghm_pkg::CMD_PIXEL, 8'haa, 8'h55, 8'haa);
    send_item(ghm_pkg::CMD_PIXEL, 8'h12, 8'h34, 8'h56);
    send_drain();
    send_drain();
  endtask

  task automatic test_pending_shrink();
    set_image_width(12'd6);
    repeat (6) send_pixel();
    repeat (3) send_drain();
    // read column now beyond the new width
    set_image_width(12'd2);
    send_drain();
    set_image_width(12'd1);
    send_drain();
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned sent;
    int unsigned w;
    int unsigned burst;
    sent = 0;
    w = eff_width(img_width);
    while (sent < budget) begin
      if ($urandom_range(99) < 85) begin
        send_pixel();
        sent++;
      end else begin
        burst = $urandom_range(1, (w + 2 > 70) ? 70 : w + 2);
        repeat (burst) begin
          send_drain();
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_frames();
    int unsigned total;
    logic [ghm_pkg::IMG_WIDTH_W-1:0] w;
    total = 0;
    while (total < 1000) begin
      case ($urandom_range(9))
        0: w = 12'd0;
        1: w = 12'd1;
        2: w = 12'd2;
        7, 8: w = 12'($urandom_range(13, 64));
        default: w = 12'($urandom_range(3, 12));
      endcase
      set_image_width(w);
      run_phase(100);
      total += 100;
    end
  endtask

  task automatic test_steady_stream();
    set_image_width(12'd5);
    stall_pct = 0;
    run_phase(200);
    settle_block();
    stall_pct = 10;
  endtask

  // widths above the limit clamp, so no row ends early; a later shrink closes the row
  task automatic test_max_width();
    set_image_width(12'd2048);
    set_image_width(12'd4095);
    repeat (40) send_pixel();
    set_image_width(12'd2049);
    set_image_width(12'd8);
    send_pixel();
    while (row_pend) send_drain();
    settle_block();
  endtask

  initial begin
    gray_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      gray_bus.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && gray_bus.valid && gray_bus.ready) begin
      if (mirror_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat gray=%0d row_last=%0b",
                                  gray_bus.gray, gray_bus.row_last));
      end else begin
        if (gray_bus.gray !== mirror_q[0].gray)
          report_mismatch($sformatf("gray %0d, want %0d", gray_bus.gray, mirror_q[0].gray));
        if (gray_bus.row_last !== mirror_q[0].row_last)
          report_mismatch($sformatf("row_last %0b, want %0b", gray_bus.row_last,
                                    mirror_q[0].row_last));
        void'(mirror_q.pop_front());
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((pixel_bus.valid && pixel_bus.ready) || (gray_bus.valid && gray_bus.ready) ||
          (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    errors = 0;
    stall_pct = 10;
    wr_col = 0;
    rd_col = 0;
    wr_bank = 1'b0;
    row_pend = 1'b0;
    bank_fill[0] = 0;
    bank_fill[1] = 0;
    img_width = ghm_pkg::IMG_WIDTH_RESET;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pixel_bus.valid <= 1'b0;
    pixel_bus.command <= ghm_pkg::CMD_PIXEL;
    pixel_bus.blue <= '0;
    pixel_bus.green <= '0;
    pixel_bus.red <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_directed_corners();
    test_pending_shrink();
    test_random_frames();
    test_steady_stream();
    test_max_width();

    settle_block();
    if (errors == 0 && mirror_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- grayscale_horizontal_mirror_top.f -----
rtl/core/ghm_pkg.sv
rtl/core/ghm_stream_if.sv
rtl/core/grayscale_horizontal_mirror_top.sv
dv/tb_grayscale_horizontal_mirror_top.sv
